@@ rtl/enc_spi_pkg.sv @@
// Shared types and constants for the encoder SPI transaction controller.
package enc_spi_pkg;

  localparam int unsigned AddrW = 14;
  localparam int unsigned FrameW = 16;
  localparam int unsigned StatW = 3;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_RESP  = 2'd2,
    OP_REJ   = 2'd3
  } op_t;

  typedef enum logic [5:0] {
    K_NONE       = 6'b000001,
    K_READ_CMD   = 6'b000010,
    K_READ_ERR   = 6'b000100,
    K_WRITE_CMD  = 6'b001000,
    K_WRITE_ERR  = 6'b010000,
    K_WRITE_DATA = 6'b100000
  } kind_t;

  localparam logic [StatW-1:0] ST_OK         = 3'd0;
  localparam logic [StatW-1:0] ST_NOT_READY  = 3'd1;
  localparam logic [StatW-1:0] ST_BUSY       = 3'd2;
  localparam logic [StatW-1:0] ST_SUBMIT     = 3'd3;
  localparam logic [StatW-1:0] ST_UNEXPECTED = 3'd4;
  localparam logic [StatW-1:0] ST_PARITY     = 3'd5;
  localparam logic [StatW-1:0] ST_ERRFLAG    = 3'd6;
  localparam logic [StatW-1:0] ST_NONE       = 3'd7;

  localparam logic [AddrW-1:0] ADDR_NOP      = 14'h0000;
  localparam logic [AddrW-1:0] ADDR_ERRFL    = 14'h0001;
  localparam logic [AddrW-1:0] ADDR_DIAAGC   = 14'h3FFC;
  localparam logic [AddrW-1:0] ADDR_MAG      = 14'h3FFD;
  localparam logic [AddrW-1:0] ADDR_ANGLEUNC = 14'h3FFE;
  localparam logic [AddrW-1:0] ADDR_ANGLECOM = 14'h3FFF;

  // classified word passed from front to back
  typedef struct packed {
    op_t               op;
    logic [AddrW-1:0]  addr;
    logic [FrameW-1:0] cmd_frame;   // command frame, parity done
    logic [FrameW-1:0] data_frame;  // write data frame, parity done
    logic              rx_bad_par;
    logic              rx_flag;
    logic [AddrW-1:0]  rx_data;
  } item_t;

  localparam int unsigned ItemW = $bits(item_t);

  typedef struct packed {
    logic              tx_valid;
    logic [FrameW-1:0] tx_frame;
    logic              busy;
    logic [StatW-1:0]  rd_st;
    logic [StatW-1:0]  wr_st;
    logic [AddrW-1:0]  c_acom;
    logic [AddrW-1:0]  c_aunc;
    logic [AddrW-1:0]  c_mag;
    logic [AddrW-1:0]  c_agc;
    logic [AddrW-1:0]  c_err;
  } result_t;

  function automatic logic [FrameW-1:0] with_parity(input logic [FrameW-2:0] w);
    return {^w, w};
  endfunction

endpackage

@@ rtl/encoder_spi_transaction_controller_top.sv @@
// Top level of the encoder SPI transaction controller.
//  channel | dir | payload
//  in_     | in  | opcode, reg_address, write_value, rx_word
//  out_    | out | tx_valid .. error_flags, one word per input word
// One word per cycle when out_tready allows; path: front register, queue, result register.
// The back end's transaction state update is the loop that sets the rate.
// Synchronous active-low reset empties all stages and sets statuses to none yet.
// A stalled output fills the queue and then drops in_tready.
module encoder_spi_transaction_controller_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [47:0]  in_tdata,   // opcode[1:0], reg_address[15:2], write_value[29:16], rx_word[45:30]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [95:0]  out_tdata   // tx_valid[0], tx_frame[16:1], busy_res[17], read_status[20:18],
                                   // write_status[23:21], angle_compensated[37:24],
                                   // angle_uncompensated[51:38], field_magnitude[65:52],
                                   // diag_agc[79:66], error_flags[93:80]
);
  import enc_spi_pkg::*;

  logic    f_valid, f_ready, b_valid, b_ready;
  item_t   f_item, b_item;
  result_t res;

  enc_spi_front u_front (.clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .q_valid(f_valid), .q_ready(f_ready), .q_item(f_item));

  enc_spi_queue u_queue (.clk, .rst_n, .wr_valid(f_valid), .wr_ready(f_ready),
    .wr_item(f_item), .rd_valid(b_valid), .rd_ready(b_ready), .rd_item(b_item));

  enc_spi_back u_back (.clk, .rst_n, .q_valid(b_valid), .q_ready(b_ready),
    .q_item(b_item), .out_tvalid, .out_tready, .res);

  assign out_tdata = {2'b00, res.c_err, res.c_agc, res.c_mag, res.c_aunc, res.c_acom,
                      res.wr_st, res.rd_st, res.busy, res.tx_frame, res.tx_valid};
endmodule

@@ rtl/enc_spi_front.sv @@
// Front end: decodes the input word, precomputes frames and response checks.
module enc_spi_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [47:0]              in_tdata,
  output logic                     q_valid,
  input  logic                     q_ready,
  output enc_spi_pkg::item_t       q_item
);
  import enc_spi_pkg::*;

  logic               v_r;
  item_t              item_r;
  item_t              item_nxt;
  logic [AddrW-1:0]   addr;
  logic [AddrW-1:0]   wval;
  logic [FrameW-1:0]  rx;

  assign addr = in_tdata[15:2];
  assign wval = in_tdata[29:16];
  assign rx   = in_tdata[45:30];
  assign in_tready = !v_r || q_ready;

  always_comb begin
    item_nxt.op         = op_t'(in_tdata[1:0]);
    item_nxt.addr       = addr;
    item_nxt.cmd_frame  = with_parity({(in_tdata[1:0] == OP_READ), addr});
    item_nxt.data_frame = with_parity({1'b0, wval});
    item_nxt.rx_bad_par = ^rx;
    item_nxt.rx_flag    = rx[14];
    item_nxt.rx_data    = rx[13:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_tready) begin
      v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r <= item_nxt;
    end
  end

  assign q_valid = v_r;
  assign q_item  = item_r;
endmodule

@@ rtl/enc_spi_queue.sv @@
// Two-entry queue between front and back end.
module enc_spi_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_valid,
  output logic                wr_ready,
  input  enc_spi_pkg::item_t  wr_item,
  output logic                rd_valid,
  input  logic                rd_ready,
  output enc_spi_pkg::item_t  rd_item
);
  import enc_spi_pkg::*;

  item_t       mem_r [2];
  logic        wp_r;
  logic        rp_r;
  logic [1:0]  cnt_r;
  logic        push;
  logic        pop;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_item  = mem_r[rp_r];
  assign push = wr_valid && wr_ready;
  assign pop  = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_item;
    end
  end
endmodule

@@ rtl/enc_spi_back.sv @@
// Back end: transaction state, status, value cache and result register.
module enc_spi_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  enc_spi_pkg::item_t   q_item,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output enc_spi_pkg::result_t res
);
  import enc_spi_pkg::*;

  kind_t              kind_r, kind_nxt;
  logic               busy_r, busy_nxt;
  logic [AddrW-1:0]   req_r, req_nxt;
  logic [StatW-1:0]   rd_r, rd_nxt, wr_r, wr_nxt;
  logic [FrameW-1:0]  held_r, held_nxt;
  logic [AddrW-1:0]   c0_r, c1_r, c2_r, c3_r, c4_r;
  logic [AddrW-1:0]   c0_nxt, c1_nxt, c2_nxt, c3_nxt, c4_nxt;
  logic               txv;
  logic [FrameW-1:0]  txf;
  logic               ov_r;
  result_t            res_r, res_nxt;
  logic               take;
  logic [FrameW-1:0]  err_frame;

  assign err_frame = with_parity({1'b1, ADDR_ERRFL});
  assign q_ready = !ov_r || out_tready;
  assign take = q_valid && q_ready;

  always_comb begin
    kind_nxt = kind_r; busy_nxt = busy_r; req_nxt = req_r;
    rd_nxt = rd_r; wr_nxt = wr_r; held_nxt = held_r;
    c0_nxt = c0_r; c1_nxt = c1_r; c2_nxt = c2_r; c3_nxt = c3_r; c4_nxt = c4_r;
    txv = 1'b0; txf = '0;
    unique case (q_item.op)
      OP_READ: begin
        if (busy_r) rd_nxt = ST_BUSY;
        else begin
          txv = 1'b1; txf = q_item.cmd_frame; kind_nxt = K_READ_CMD;
          req_nxt = q_item.addr; rd_nxt = ST_NOT_READY; busy_nxt = 1'b1;
        end
      end
      OP_WRITE: begin
        if (busy_r) wr_nxt = ST_BUSY;
        else begin
          txv = 1'b1; txf = q_item.cmd_frame; held_nxt = q_item.data_frame;
          kind_nxt = K_WRITE_CMD; wr_nxt = ST_NOT_READY; busy_nxt = 1'b1;
        end
      end
      OP_REJ: begin
        if (kind_r == K_READ_CMD || kind_r == K_READ_ERR) begin
          kind_nxt = K_NONE; busy_nxt = 1'b0; rd_nxt = ST_SUBMIT;
        end else if (kind_r != K_NONE) begin
          kind_nxt = K_NONE; busy_nxt = 1'b0; wr_nxt = ST_SUBMIT;
        end
      end
      default: begin
        priority case (kind_r)
          K_READ_CMD, K_READ_ERR: begin
            if (q_item.rx_bad_par) begin
              req_nxt = ADDR_NOP; kind_nxt = K_NONE; busy_nxt = 1'b0;
              rd_nxt = ST_PARITY;
            end else if (q_item.rx_flag && kind_r == K_READ_CMD) begin
              txv = 1'b1; txf = err_frame; kind_nxt = K_READ_ERR;
              req_nxt = ADDR_ERRFL; rd_nxt = ST_ERRFLAG;
            end else begin
              if (kind_r == K_READ_ERR) c4_nxt = q_item.rx_data;
              else begin
                rd_nxt = ST_OK;
                unique case (req_r)
                  ADDR_ANGLECOM: c0_nxt = q_item.rx_data;
                  ADDR_ANGLEUNC: c1_nxt = q_item.rx_data;
                  ADDR_MAG:      c2_nxt = q_item.rx_data;
                  ADDR_DIAAGC:   c3_nxt = q_item.rx_data;
                  ADDR_ERRFL:    c4_nxt = q_item.rx_data;
                  default: ;
                endcase
              end
              kind_nxt = K_NONE; busy_nxt = 1'b0;
            end
          end
          K_WRITE_CMD: begin
            if (q_item.rx_bad_par) begin
              kind_nxt = K_NONE; busy_nxt = 1'b0; wr_nxt = ST_PARITY;
            end else if (q_item.rx_flag) begin
              txv = 1'b1; txf = err_frame; kind_nxt = K_WRITE_ERR;
              wr_nxt = ST_ERRFLAG;
            end else begin
              txv = 1'b1; txf = held_r; kind_nxt = K_WRITE_DATA;
            end
          end
          K_WRITE_ERR: begin
            if (!q_item.rx_bad_par) c4_nxt = q_item.rx_data;
            kind_nxt = K_NONE; busy_nxt = 1'b0;
          end
          K_WRITE_DATA: begin
            kind_nxt = K_NONE; busy_nxt = 1'b0; wr_nxt = ST_OK;
          end
          default: begin
            kind_nxt = K_NONE; busy_nxt = 1'b0; rd_nxt = ST_UNEXPECTED;
          end
        endcase
      end
    endcase
    res_nxt = '{tx_valid: txv, tx_frame: txf, busy: busy_nxt, rd_st: rd_nxt,
                wr_st: wr_nxt, c_acom: c0_nxt, c_aunc: c1_nxt, c_mag: c2_nxt,
                c_agc: c3_nxt, c_err: c4_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= K_NONE; busy_r <= 1'b0; req_r <= ADDR_NOP;
      rd_r <= ST_NONE; wr_r <= ST_NONE; held_r <= '0;
      c0_r <= '0; c1_r <= '0; c2_r <= '0; c3_r <= '0; c4_r <= '0;
      ov_r <= 1'b0;
    end else begin
      if (q_ready) ov_r <= q_valid;
      if (take) begin
        kind_r <= kind_nxt; busy_r <= busy_nxt; req_r <= req_nxt;
        rd_r <= rd_nxt; wr_r <= wr_nxt; held_r <= held_nxt;
        c0_r <= c0_nxt; c1_r <= c1_nxt; c2_r <= c2_nxt;
        c3_r <= c3_nxt; c4_r <= c4_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) res_r <= res_nxt;
  end

  assign out_tvalid = ov_r;
  assign res = res_r;
endmodule

@@ bench/testbench.sv @@
// Self-checking testbench for the encoder SPI transaction controller top level.
module testbench;
  import enc_spi_pkg::*;

  typedef struct packed {
    logic [15:0] rx;
    logic [13:0] wval;
    logic [13:0] addr;
    op_t         op;
  } req_t;

  typedef struct packed {
    logic        txv;
    logic [15:0] txf;
    logic        busy;
    logic [2:0]  rd;
    logic [2:0]  wr;
    logic [13:0] c0, c1, c2, c3, c4;
  } status_t;

  localparam int WatchLimit = 20000;
  localparam int NumRandom = 1850;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [47:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [95:0] out_tdata;

  encoder_spi_transaction_controller_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  req_t    pending_words[$];
  status_t expected_status[$];
  int      errors = 0;
  int      quiet_cycles = 0;
  bit      stim_done = 0;
  bit      calm = 0;

  // controller model state
  kind_t      kind_q;
  logic       busy_q;
  logic [13:0] req_reg;
  logic [2:0] rd_q, wr_q;
  logic [15:0] held_frame;
  logic [13:0] cache_q[5];

  function automatic logic [15:0] frame_of(logic [14:0] w);
    return {^w, w};
  endfunction

  task automatic controller_step(input req_t r);
    status_t s;
    logic bad, flg;
    logic [13:0] d;
    s = '0;
    bad = ^r.rx;
    flg = r.rx[14];
    d = r.rx[13:0];
    case (r.op)
      OP_READ: begin
        if (busy_q) rd_q = ST_BUSY;
        else begin
          s.txv = 1; s.txf = frame_of({1'b1, r.addr});
          kind_q = K_READ_CMD; req_reg = r.addr; rd_q = ST_NOT_READY; busy_q = 1;
        end
      end
      OP_WRITE: begin
        if (busy_q) wr_q = ST_BUSY;
        else begin
          s.txv = 1; s.txf = frame_of({1'b0, r.addr});
          held_frame = frame_of({1'b0, r.wval});
          kind_q = K_WRITE_CMD; wr_q = ST_NOT_READY; busy_q = 1;
        end
      end
      OP_REJ: begin
        if (kind_q == K_READ_CMD || kind_q == K_READ_ERR) begin
          kind_q = K_NONE; busy_q = 0; rd_q = ST_SUBMIT;
        end else if (kind_q != K_NONE) begin
          kind_q = K_NONE; busy_q = 0; wr_q = ST_SUBMIT;
        end
      end
      default: begin
        if (kind_q == K_READ_CMD || kind_q == K_READ_ERR) begin
          if (bad) begin
            req_reg = ADDR_NOP; kind_q = K_NONE; busy_q = 0; rd_q = ST_PARITY;
          end else if (flg && kind_q == K_READ_CMD) begin
            s.txv = 1; s.txf = frame_of({1'b1, ADDR_ERRFL});
            kind_q = K_READ_ERR; req_reg = ADDR_ERRFL; rd_q = ST_ERRFLAG;
          end else begin
            if (kind_q == K_READ_ERR) cache_q[4] = d;
            else begin
              case (req_reg)
                ADDR_ANGLECOM: cache_q[0] = d;
                ADDR_ANGLEUNC: cache_q[1] = d;
                ADDR_MAG:      cache_q[2] = d;
                ADDR_DIAAGC:   cache_q[3] = d;
                ADDR_ERRFL:    cache_q[4] = d;
                default: ;
              endcase
              rd_q = ST_OK;
            end
            kind_q = K_NONE; busy_q = 0;
          end
        end else if (kind_q == K_WRITE_CMD) begin
          if (bad) begin
            kind_q = K_NONE; busy_q = 0; wr_q = ST_PARITY;
          end else if (flg) begin
            s.txv = 1; s.txf = frame_of({1'b1, ADDR_ERRFL});
            kind_q = K_WRITE_ERR; wr_q = ST_ERRFLAG;
          end else begin
            s.txv = 1; s.txf = held_frame; kind_q = K_WRITE_DATA;
          end
        end else if (kind_q == K_WRITE_ERR) begin
          if (!bad) cache_q[4] = d;
          kind_q = K_NONE; busy_q = 0;
        end else if (kind_q == K_WRITE_DATA) begin
          kind_q = K_NONE; busy_q = 0; wr_q = ST_OK;
        end else begin
          kind_q = K_NONE; busy_q = 0; rd_q = ST_UNEXPECTED;
        end
      end
    endcase
    s.busy = busy_q; s.rd = rd_q; s.wr = wr_q;
    s.c0 = cache_q[0]; s.c1 = cache_q[1]; s.c2 = cache_q[2];
    s.c3 = cache_q[3]; s.c4 = cache_q[4];
    expected_status.push_back(s);
  endtask

  function automatic req_t mk(op_t op, logic [13:0] a, logic [13:0] w, logic [15:0] rx);
    req_t r;
    r.op = op; r.addr = a; r.wval = w; r.rx = rx;
    return r;
  endfunction

  // response word: parity good unless bad, flag as asked
  function automatic logic [15:0] resp(bit flg, bit bad_par);
    logic [14:0] w;
    w = {flg, 14'($urandom)};
    return {^w ^ bad_par, w};
  endfunction

  function automatic logic [13:0] pick_addr();
    case ($urandom_range(0, 6))
      0: return ADDR_ANGLECOM;
      1: return ADDR_ANGLEUNC;
      2: return ADDR_MAG;
      3: return ADDR_DIAAGC;
      4: return ADDR_ERRFL;
      5: return ADDR_NOP;
      default: return 14'($urandom);
    endcase
  endfunction

  initial begin
    bit flg;
    pending_words.push_back(mk(OP_RESP, 0, 0, 16'hFFFF));               // stray response
    pending_words.push_back(mk(OP_REJ, 0, 0, 0));                       // reject, idle
    pending_words.push_back(mk(OP_READ, ADDR_ANGLECOM, 0, 0));
    pending_words.push_back(mk(OP_WRITE, 14'h3FFF, 14'h3FFF, 0));        // start while busy
    pending_words.push_back(mk(OP_READ, 0, 0, 0));                      // start while busy
    pending_words.push_back(mk(OP_RESP, 0, 0, 16'h3FFF));                // clean, cached
    pending_words.push_back(mk(OP_READ, ADDR_MAG, 0, 0));
    pending_words.push_back(mk(OP_RESP, 0, 0, 16'h0001));                // bad parity
    pending_words.push_back(mk(OP_READ, ADDR_DIAAGC, 0, 0));
    pending_words.push_back(mk(OP_RESP, 0, 0, 16'h4000 | 16'h8000));     // error flag
    pending_words.push_back(mk(OP_RESP, 0, 0, 16'hC000));                // flag on follow-up
    pending_words.push_back(mk(OP_READ, 14'h1234, 0, 0));                // no cache slot
    pending_words.push_back(mk(OP_RESP, 0, 0, 16'h0000));
    pending_words.push_back(mk(OP_WRITE, ADDR_ANGLEUNC, 14'h2AAA, 0));
    pending_words.push_back(mk(OP_RESP, 0, 0, 16'h0000));                // clean -> data frame
    pending_words.push_back(mk(OP_RESP, 0, 0, 16'h0001));                // data resp unchecked
    pending_words.push_back(mk(OP_WRITE, 14'h0000, 14'h0000, 0));
    pending_words.push_back(mk(OP_RESP, 0, 0, 16'hC000));                // flagged write
    pending_words.push_back(mk(OP_RESP, 0, 0, 16'h8000));                // follow-up bad parity
    pending_words.push_back(mk(OP_WRITE, 14'h1555, 14'h1555, 0));
    pending_words.push_back(mk(OP_RESP, 0, 0, 16'h8000));                // write cmd bad parity
    pending_words.push_back(mk(OP_READ, ADDR_ERRFL, 0, 0));
    pending_words.push_back(mk(OP_REJ, 0, 0, 0));                       // reject read
    pending_words.push_back(mk(OP_WRITE, 1, 2, 0));
    pending_words.push_back(mk(OP_REJ, 0, 0, 0));                       // reject write
    while (pending_words.size() < NumRandom) begin
      if ($urandom_range(0, 9) == 0) begin
        pending_words.push_back(mk(op_t'($urandom_range(0, 3)), 14'($urandom),
                                   14'($urandom), 16'($urandom)));
      end else if ($urandom_range(0, 1) == 0) begin
        flg = $urandom_range(0, 3) == 0;
        pending_words.push_back(mk(OP_READ, pick_addr(), 14'($urandom), 16'($urandom)));
        if ($urandom_range(0, 7) == 0)
          pending_words.push_back(mk(OP_WRITE, 14'($urandom), 14'($urandom), 0));
        if ($urandom_range(0, 11) == 0) pending_words.push_back(mk(OP_REJ, 0, 0, 0));
        else begin
          pending_words.push_back(mk(OP_RESP, 0, 0, resp(flg, $urandom_range(0, 9) == 0)));
          if (flg) pending_words.push_back(mk(OP_RESP, 0, 0,
                                     resp($urandom_range(0, 1), $urandom_range(0, 7) == 0)));
        end
      end else begin
        flg = $urandom_range(0, 3) == 0;
        pending_words.push_back(mk(OP_WRITE, pick_addr(), 14'($urandom), 0));
        if ($urandom_range(0, 11) == 0) pending_words.push_back(mk(OP_REJ, 0, 0, 0));
        else begin
          pending_words.push_back(mk(OP_RESP, 0, 0, resp(flg, $urandom_range(0, 9) == 0)));
          pending_words.push_back(mk(OP_RESP, 0, 0, resp($urandom_range(0, 1),
                                                          $urandom_range(0, 5) == 0)));
        end
      end
    end
    stim_done = 1;
  end

  initial begin
    kind_q = K_NONE; busy_q = 0; req_reg = ADDR_NOP;
    rd_q = ST_NONE; wr_q = ST_NONE; held_frame = '0;
    foreach (cache_q[i]) cache_q[i] = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1;
  end

  // no-idle stretch in the middle of the run
  always @(posedge clk) calm <= (pending_words.size() > 700 && pending_words.size() < 1100);

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        controller_step(req_t'(in_tdata[45:0]));
        void'(pending_words.pop_front());
      end
      if (pending_words.size() > 0 && (calm || $urandom_range(0, 99) >= 21)) begin
        in_tvalid <= 1;
        in_tdata <= {2'b0, pending_words[0]};
      end else if (!(in_tvalid && !in_tready)) begin
        in_tvalid <= 0;
      end
      out_tready <= calm || $urandom_range(0, 99) >= 21;
    end
  end

  // monitor
  always @(posedge clk) begin
    status_t got, exp_s;
    if (rst_n && out_tvalid && out_tready) begin
      got = status_t'({out_tdata[0], out_tdata[16:1], out_tdata[17], out_tdata[20:18],
                       out_tdata[23:21], out_tdata[37:24], out_tdata[51:38],
                       out_tdata[65:52], out_tdata[79:66], out_tdata[93:80]});
      if (expected_status.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        exp_s = expected_status.pop_front();
        if (got.txv !== exp_s.txv) begin
          $error("tx_valid exp %0d got %0d", exp_s.txv, got.txv); errors++;
        end
        if (got.txf !== exp_s.txf) begin
          $error("tx_frame exp %h got %h", exp_s.txf, got.txf); errors++;
        end
        if (got.busy !== exp_s.busy) begin
          $error("busy_res exp %0d got %0d", exp_s.busy, got.busy); errors++;
        end
        if (got.rd !== exp_s.rd) begin
          $error("read_status exp %0d got %0d", exp_s.rd, got.rd); errors++;
        end
        if (got.wr !== exp_s.wr) begin
          $error("write_status exp %0d got %0d", exp_s.wr, got.wr); errors++;
        end
        if (got.c0 !== exp_s.c0) begin
          $error("angle_compensated exp %h got %h", exp_s.c0, got.c0); errors++;
        end
        if (got.c1 !== exp_s.c1) begin
          $error("angle_uncompensated exp %h got %h", exp_s.c1, got.c1); errors++;
        end
        if (got.c2 !== exp_s.c2) begin
          $error("field_magnitude exp %h got %h", exp_s.c2, got.c2); errors++;
        end
        if (got.c3 !== exp_s.c3) begin
          $error("diag_agc exp %h got %h", exp_s.c3, got.c3); errors++;
        end
        if (got.c4 !== exp_s.c4) begin
          $error("error_flags exp %h got %h", exp_s.c4, got.c4); errors++;
        end
      end
    end
  end

  // watchdog and end of run
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (quiet_cycles >= WatchLimit) begin
        $display("FAIL encoder_spi_transaction_controller_top");
        $finish;
      end
      if (stim_done && pending_words.size() == 0 && !in_tvalid &&
          expected_status.size() == 0) begin
        repeat (20) @(posedge clk);
        if (errors == 0 && expected_status.size() == 0)
          $display("PASS encoder_spi_transaction_controller_top");
        else
          $display("FAIL encoder_spi_transaction_controller_top");
        $finish;
      end
    end
  end

endmodule
